FILE: sv/lssc_pkg.sv
`timescale 1ns / 1ps

package lssc_pkg;

    // Samples taken from each channel before the multiplexer moves on.
    localparam int SAMPLES_PER_CHANNEL = 9;
    localparam int SAMPLE_W            = 4;
    localparam int CHANNELS            = 8;
    localparam int CHAN_W              = 3;

    localparam logic [SAMPLE_W-1:0] LAST_SAMPLE = SAMPLE_W'(SAMPLES_PER_CHANNEL - 1);
    localparam logic [SAMPLE_W-1:0] FULL_TALLY  = SAMPLE_W'(SAMPLES_PER_CHANNEL);
    localparam logic [CHAN_W-1:0]   LAST_CHAN   = CHAN_W'(CHANNELS - 1);

    // Divider geometry: the magnitude of the weight sum fits in 13 bits.
    localparam int DIV_W     = 13;
    localparam int DIVISOR_W = 4;
    localparam int SUM_W     = DIV_W + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE  = 2'd1;
    localparam int CFG_DATA_W = 6;

    // Mode codes.
    localparam logic [1:0] MODE_CALIB   = 2'd1;
    localparam logic [1:0] MODE_UNIFORM = 2'd2;
    localparam logic [1:0] MODE_MIXED   = 2'd3;

    // Baseline kind codes.
    localparam logic [1:0] LVL_LOW   = 2'd0;
    localparam logic [1:0] LVL_HIGH  = 2'd1;
    localparam logic [1:0] LVL_MIXED = 2'd2;

    // LED blink periods in scans; the phase counter runs over twice the slow period.
    localparam logic [4:0] BLINK_SLOW = 5'd10;
    localparam logic [4:0] BLINK_FAST = 5'd5;
    localparam logic [4:0] PHASE_LAST = 5'd19;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SUM,
        ST_DSTART,
        ST_DIV,
        ST_OUT
    } t_state;

    // Position weight of each channel.
    function automatic logic signed [DIV_W-1:0] weight(input logic [CHAN_W-1:0] ch);
        logic signed [DIV_W-1:0] w;
        unique case (ch)
            3'd0:    w = -13'sd3500;
            3'd1:    w = -13'sd2500;
            3'd2:    w = -13'sd1500;
            3'd3:    w = -13'sd500;
            3'd4:    w = 13'sd500;
            3'd5:    w = 13'sd1500;
            3'd6:    w = 13'sd2500;
            default: w = 13'sd3500;
        endcase
        return w;
    endfunction

    function automatic logic [1:0] level_code(input logic [CHANNELS-1:0] m);
        logic [1:0] c;
        if (m == '0) begin
            c = LVL_LOW;
        end else if (m == '1) begin
            c = LVL_HIGH;
        end else begin
            c = LVL_MIXED;
        end
        return c;
    endfunction

endpackage

FILE: sv/lssc_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module lssc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [lssc_pkg::DIV_W-1:0]          i_dividend,
    input  logic [lssc_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic                                o_done,
    output logic [lssc_pkg::DIV_W-1:0]          o_quotient
);

    logic                                 r_busy;
    logic                                 r_done;
    logic [3:0]                           r_step;
    logic [lssc_pkg::DIVISOR_W-1:0]       r_rem;
    logic [lssc_pkg::DIVISOR_W-1:0]       r_divr;
    logic [lssc_pkg::DIV_W-1:0]           r_quo;
    logic [lssc_pkg::DIVISOR_W-1:0]       n_trial;
    logic                                 n_bit;

    // The remainder stays below the divisor, which is at most 8 here, so the shifted trial fits.
    assign n_trial = {r_rem[lssc_pkg::DIVISOR_W-2:0], r_quo[lssc_pkg::DIV_W-1]};
    assign n_bit   = (n_trial >= r_divr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 4'(lssc_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_divr <= i_divisor;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= n_bit ? (n_trial - r_divr) : n_trial;
            r_quo  <= {r_quo[lssc_pkg::DIV_W-2:0], n_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: sv/line_sensor_scan_calibrate.sv
`timescale 1ns / 1ps

// Scan and calibration core for a multiplexed 8-channel line sensor. Each input word is one
// sampled level; nine samples per channel arrive for channels 0 through 7 in order, and the
// block returns one result word after the last sample of channel 7. Every sample except the
// last one of a scan leaves the block ready for the next. The last one starts end-of-scan
// work: an evaluation state during calibration, and after calibration an evaluation state, a
// walk over the channels through one shared adder to build the weight sum, a start state and
// a bit-serial divider for the mean position (thirteen quotient bits, then handing the
// quotient back). The divider is skipped when no channel differs from the baseline. The block
// is not ready again until the result is loaded into the output register, which waits while
// that register still holds an untaken result. The result word sits in an output register, so
// the next scan's samples are accepted while it waits to be taken. The first baseline_scans
// scans vote a white baseline by per-channel majority, a tie counting as white; later scans
// report the difference from it, a change event and the truncated mean channel weight from
// -3500 to 3500. Configuration writes are always accepted and must be made only while the
// block is idle.
module line_sensor_scan_calibrate (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample channel.
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_level,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_raw_mask,
    output logic [7:0]                          o_noisy_mask,
    output logic [7:0]                          o_delta_mask,
    output logic                                o_change_event,
    output logic                                o_baseline_ready,
    output logic [1:0]                          o_white_level,
    output logic                                o_line_valid,
    output logic [3:0]                          o_changed_count,
    output logic signed [12:0]                  o_line_error,
    output logic [1:0]                          o_mode,
    output logic                                o_led,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lssc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lssc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int NCH = lssc_pkg::CHANNELS;

    lssc_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic [3:0]                         r_threshold;
    logic [5:0]                         r_baseline_scans;

    // Sampling state.
    logic [lssc_pkg::SAMPLE_W-1:0]      r_sample;
    logic [lssc_pkg::SAMPLE_W-1:0]      r_tally;
    logic [lssc_pkg::CHAN_W-1:0]        r_chan;
    logic [NCH-1:0]                     r_mask_bld;
    logic [NCH-1:0]                     r_unst_bld;

    // Calibration and tracking state.
    logic [5:0]                         r_votes [NCH];
    logic [5:0]                         r_calib_count;
    logic                               r_bl_ready;
    logic [NCH-1:0]                     r_white;
    logic [NCH-1:0]                     r_prev_changed;
    logic [1:0]                         r_test_state;
    logic [31:0]                        r_scan_count;
    logic [4:0]                         r_phase;

    // End-of-scan working registers.
    logic [NCH-1:0]                     r_raw;
    logic [NCH-1:0]                     r_unst;
    logic [NCH-1:0]                     r_changed;
    logic                               r_event;
    logic [lssc_pkg::CHAN_W-1:0]        r_idx;
    logic signed [lssc_pkg::SUM_W-1:0]  r_sum;
    logic [3:0]                         r_ccount;
    logic signed [12:0]                 r_err;

    // Output register.
    logic                               r_o_valid;
    logic [7:0]                         r_o_raw;
    logic [7:0]                         r_o_unst;
    logic [7:0]                         r_o_changed;
    logic                               r_o_event;
    logic                               r_o_bl_ready;
    logic [1:0]                         r_o_white;
    logic                               r_o_line_valid;
    logic [3:0]                         r_o_ccount;
    logic signed [12:0]                 r_o_err;
    logic [1:0]                         r_o_mode;
    logic                               r_o_led;

    // Sequencer outputs.
    logic                               w_accept;
    logic                               w_div_start;
    logic                               w_load_out;

    // Sample datapath.
    logic [lssc_pkg::SAMPLE_W-1:0]      w_cnt;
    logic [NCH-1:0]                     w_mask_full;
    logic [NCH-1:0]                     w_unst_full;
    logic                               w_last_sample;
    logic                               w_scan_end;
    logic [31:0]                        w_scan_next;

    // Calibration datapath.
    logic [5:0]                         w_votes_next [NCH];
    logic [5:0]                         w_calib_next;
    logic [5:0]                         w_vote_thr;
    logic [NCH-1:0]                     w_white_next;
    logic                               w_calib_done;

    // Division.
    logic [lssc_pkg::DIV_W-1:0]         w_sum_mag;
    logic                               w_div_done;
    logic [lssc_pkg::DIV_W-1:0]         w_quotient;
    logic                               w_led;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold      <= 4'd5;
            r_baseline_scans <= 6'd50;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lssc_pkg::CFG_THRESHOLD: r_threshold      <= i_cfg_data[3:0];
                lssc_pkg::CFG_BASELINE:  r_baseline_scans <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Per-sample tally. The tally never exceeds the sample count, so 4 bits hold it.
    assign w_cnt         = r_tally + lssc_pkg::SAMPLE_W'(i_level);
    assign w_last_sample = (r_sample == lssc_pkg::LAST_SAMPLE);
    assign w_mask_full   = r_mask_bld
                         | (NCH'(w_cnt >= r_threshold) << r_chan);
    assign w_unst_full   = r_unst_bld
                         | (NCH'((w_cnt != '0) && (w_cnt != lssc_pkg::FULL_TALLY)) << r_chan);
    assign w_scan_end    = w_last_sample && (r_chan == lssc_pkg::LAST_CHAN);
    assign w_scan_next   = r_scan_count + 32'd1;

    // Calibration votes include the scan just finished.
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            w_votes_next[i] = r_votes[i] + 6'(r_raw[i]);
            w_white_next[i] = (w_votes_next[i] >= w_vote_thr);
        end
    end
    assign w_calib_next = r_calib_count + 6'd1;
    assign w_vote_thr   = 6'((7'(r_baseline_scans) + 7'd1) >> 1);
    assign w_calib_done = (w_calib_next >= r_baseline_scans);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lssc_pkg::ST_IDLE: begin
                if (i_valid && w_scan_end) begin
                    n_state = lssc_pkg::ST_EVAL;
                end
            end
            lssc_pkg::ST_EVAL: begin
                n_state = r_bl_ready ? lssc_pkg::ST_SUM : lssc_pkg::ST_OUT;
            end
            lssc_pkg::ST_SUM: begin
                if (r_idx == lssc_pkg::LAST_CHAN) begin
                    n_state = lssc_pkg::ST_DSTART;
                end
            end
            lssc_pkg::ST_DSTART: begin
                n_state = (r_ccount == '0) ? lssc_pkg::ST_OUT : lssc_pkg::ST_DIV;
            end
            lssc_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = lssc_pkg::ST_OUT;
                end
            end
            lssc_pkg::ST_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_state = lssc_pkg::ST_IDLE;
                end
            end
            default: n_state = lssc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_ready     = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            lssc_pkg::ST_IDLE:   o_ready     = 1'b1;
            lssc_pkg::ST_DSTART: w_div_start = (r_ccount != '0);
            lssc_pkg::ST_OUT:    w_load_out  = !r_o_valid || i_ready;
            default: ;
        endcase
    end
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lssc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sampling and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample     <= '0;
            r_tally      <= '0;
            r_chan       <= '0;
            r_mask_bld   <= '0;
            r_unst_bld   <= '0;
            r_scan_count <= '0;
            r_phase      <= '0;
        end else if (w_accept) begin
            if (!w_last_sample) begin
                r_sample <= r_sample + lssc_pkg::SAMPLE_W'(1);
                r_tally  <= w_cnt;
            end else begin
                r_sample <= '0;
                r_tally  <= '0;
                if (r_chan != lssc_pkg::LAST_CHAN) begin
                    r_chan     <= r_chan + lssc_pkg::CHAN_W'(1);
                    r_mask_bld <= w_mask_full;
                    r_unst_bld <= w_unst_full;
                end else begin
                    r_chan       <= '0;
                    r_mask_bld   <= '0;
                    r_unst_bld   <= '0;
                    r_scan_count <= w_scan_next;
                    // The phase tracks the scan count modulo twenty, including the wrap.
                    if (w_scan_next == '0 || r_phase == lssc_pkg::PHASE_LAST) begin
                        r_phase <= '0;
                    end else begin
                        r_phase <= r_phase + 5'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_scan_end) begin
            r_raw  <= w_mask_full;
            r_unst <= w_unst_full;
        end
    end

    // Calibration and baseline comparison.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_votes[i] <= '0;
            end
            r_calib_count  <= '0;
            r_bl_ready     <= 1'b0;
            r_white        <= '0;
            r_prev_changed <= '0;
            r_test_state   <= lssc_pkg::MODE_CALIB;
        end else if (r_state == lssc_pkg::ST_EVAL) begin
            if (!r_bl_ready) begin
                r_votes       <= w_votes_next;
                r_calib_count <= w_calib_next;
                if (w_calib_done) begin
                    r_white        <= w_white_next;
                    r_bl_ready     <= 1'b1;
                    r_prev_changed <= '0;
                    r_test_state   <= (lssc_pkg::level_code(w_white_next) == lssc_pkg::LVL_MIXED)
                                    ? lssc_pkg::MODE_MIXED : lssc_pkg::MODE_UNIFORM;
                end
            end else begin
                r_prev_changed <= r_raw ^ r_white;
            end
        end
    end

    // Weight sum over the changed channels, one channel per cycle through one adder.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lssc_pkg::ST_EVAL: begin
                r_changed <= r_bl_ready ? (r_raw ^ r_white) : '0;
                r_event   <= r_bl_ready && ((r_raw ^ r_white) != r_prev_changed);
                r_idx     <= '0;
                r_sum     <= '0;
                r_ccount  <= '0;
                r_err     <= '0;
            end
            lssc_pkg::ST_SUM: begin
                if (r_changed[r_idx]) begin
                    r_sum    <= r_sum + lssc_pkg::SUM_W'(lssc_pkg::weight(r_idx));
                    r_ccount <= r_ccount + 4'd1;
                end
                r_idx <= r_idx + lssc_pkg::CHAN_W'(1);
            end
            lssc_pkg::ST_DIV: begin
                if (w_div_done) begin
                    // Dividing the magnitude and restoring the sign truncates toward zero.
                    r_err <= r_sum[lssc_pkg::SUM_W-1] ? -$signed(w_quotient)
                                                      : $signed(w_quotient);
                end
            end
            default: ;
        endcase
    end

    assign w_sum_mag = r_sum[lssc_pkg::SUM_W-1] ? lssc_pkg::DIV_W'(-r_sum)
                                                : lssc_pkg::DIV_W'(r_sum);

    lssc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_sum_mag),
        .i_divisor  (r_ccount),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // The slow blink toggles every ten scans and the fast one every five.
    always_comb begin
        unique case (r_test_state)
            lssc_pkg::MODE_CALIB: w_led = (r_phase >= lssc_pkg::BLINK_SLOW);
            lssc_pkg::MODE_MIXED: w_led = (r_phase >= lssc_pkg::BLINK_FAST
                                           && r_phase < lssc_pkg::BLINK_SLOW)
                                       || (r_phase >= (lssc_pkg::BLINK_SLOW
                                                       + lssc_pkg::BLINK_FAST));
            default:              w_led = (r_changed != '0);
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_raw        <= r_raw;
            r_o_unst       <= r_unst;
            r_o_changed    <= r_changed;
            r_o_event      <= r_event;
            r_o_bl_ready   <= r_bl_ready;
            r_o_white      <= r_bl_ready ? lssc_pkg::level_code(r_white) : lssc_pkg::LVL_MIXED;
            r_o_line_valid <= (r_ccount != '0);
            r_o_ccount     <= r_ccount;
            r_o_err        <= r_err;
            r_o_mode       <= r_test_state;
            r_o_led        <= w_led;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_raw_mask       = r_o_raw;
    assign o_noisy_mask     = r_o_unst;
    assign o_delta_mask     = r_o_changed;
    assign o_change_event   = r_o_event;
    assign o_baseline_ready = r_o_bl_ready;
    assign o_white_level    = r_o_white;
    assign o_line_valid     = r_o_line_valid;
    assign o_changed_count  = r_o_ccount;
    assign o_line_error     = r_o_err;
    assign o_mode           = r_o_mode;
    assign o_led            = r_o_led;

endmodule
